[rtl/core/spm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg: shared definitions for the sparse polynomial merge adder
// Sizes, operation codes and the stored term layout used by the adder, its ALU and the bench.
// ----------------------------------------------------------------------------
package spm_pkg;

   // list capacity and stored exponent width
   localparam int MAX_TERMS   = 32;
   localparam int POWER_WIDTH = 16;

   // fixed port widths
   localparam int FUNC_W   = 2;
   localparam int COEF_W   = 32;
   localparam int SUM_W    = COEF_W + 1;
   localparam int POW_IO_W = 16;

   // derived sizes
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int POW_EXT_W = (POWER_WIDTH > POW_IO_W) ? POWER_WIDTH : POW_IO_W;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

   // request operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_A = 2'd0,
      FUNC_LOAD_B = 2'd1,
      FUNC_MERGE  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // one stored term
   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic [POWER_WIDTH-1:0]   power;
   } term_type;

   localparam int TERM_W = $bits(term_type);

   // which list heads the current output term consumes
   typedef struct packed {
      logic take_a;
      logic take_b;
   } sel_type;

endpackage

[rtl/core/sparse_polynomial_merge_add.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add: sparse polynomial adder by sorted merge
// Collects two term lists and merges them into their sum on request.
// ----------------------------------------------------------------------------
// Load beats (func 0 for list A, 1 for list B) each append a term; loads
// into a full list are dropped and set the sticky overflow flag.
// A merge beat walks both lists from the front, highest power first, and
// returns one result beat per output term, marking the final one with last.
// The input stalls for the whole merge. Each output term passes a read state,
// for the registered read of the term memories that precedes each compare
// and add, then an emit state that waits while the result side stalls.
// A merge of two empty lists returns a single beat with empty_res and last
// set. Both lists are cleared when the last result is registered, so loads
// for the next polynomial may begin while that beat is still waiting.
// ----------------------------------------------------------------------------
module sparse_polynomial_merge_add (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [spm_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [spm_pkg::COEF_W-1:0] req_coef,
   input  logic [spm_pkg::POW_IO_W-1:0]      req_power,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [spm_pkg::SUM_W-1:0]  rsp_sum_coef,
   output logic [spm_pkg::POW_IO_W-1:0]      rsp_out_power,
   output logic                              rsp_last,
   output logic                              rsp_empty_res,
   output logic                              rsp_overflow
);
   import spm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in;
   logic [CNT_W-1:0] b_cnt_ff, b_cnt_in;
   logic [CNT_W-1:0] a_idx_ff, a_idx_in;
   logic [CNT_W-1:0] b_idx_ff, b_idx_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // result payload
   logic signed [SUM_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [POW_IO_W-1:0]     rsp_power_ff, rsp_power_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // datapath
   func_type               func;
   logic                   req_fire;
   logic                   a_full, b_full;
   logic                   wr_a, wr_b;
   logic [POW_EXT_W-1:0]   pow_in_ext;
   logic [POW_EXT_W-1:0]   pow_out_ext;
   term_type               wr_term;
   term_type               a_term, b_term;
   logic                   a_live, b_live;
   logic signed [SUM_W-1:0] term_coef;
   logic [POWER_WIDTH-1:0] term_power;
   sel_type                sel;
   logic [CNT_W-1:0]       a_idx_next, b_idx_next;
   logic                   term_last;
   logic                   term_empty;
   logic                   out_free;
   logic                   out_load;

   assign func     = func_type'(req_func);
   assign req_fire = req_valid && !req_stall;

   // load path: stored power is masked to the configured width
   assign pow_in_ext    = POW_EXT_W'(req_power);
   assign wr_term.coef  = req_coef;
   assign wr_term.power = pow_in_ext[POWER_WIDTH-1:0];

   assign a_full = (a_cnt_ff == MAX_CNT);
   assign b_full = (b_cnt_ff == MAX_CNT);
   assign wr_a   = req_fire && (func == FUNC_LOAD_A) && !a_full;
   assign wr_b   = req_fire && (func == FUNC_LOAD_B) && !b_full;

   // term stores
   spm_ram #(
      .WIDTH (TERM_W),
      .DEPTH (MAX_TERMS)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (a_cnt_ff[ADDR_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (a_idx_ff[ADDR_W-1:0]),
      .rd_data (a_term)
   );

   spm_ram #(
      .WIDTH (TERM_W),
      .DEPTH (MAX_TERMS)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (b_cnt_ff[ADDR_W-1:0]),
      .wr_data (wr_term),
      .rd_addr (b_idx_ff[ADDR_W-1:0]),
      .rd_data (b_term)
   );

   // shared compare/add unit
   assign a_live = (a_idx_ff != a_cnt_ff);
   assign b_live = (b_idx_ff != b_cnt_ff);

   spm_alu u_alu (
      .a_live     (a_live),
      .b_live     (b_live),
      .a_term     (a_term),
      .b_term     (b_term),
      .term_coef  (term_coef),
      .term_power (term_power),
      .sel        (sel)
   );

   assign a_idx_next  = a_idx_ff + CNT_W'(sel.take_a);
   assign b_idx_next  = b_idx_ff + CNT_W'(sel.take_b);
   assign term_empty  = !a_live && !b_live;
   assign term_last   = (a_idx_next == a_cnt_ff) && (b_idx_next == b_cnt_ff);
   assign pow_out_ext = POW_EXT_W'(term_power);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_EMIT) && out_free;

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      a_cnt_in   = a_cnt_ff;
      b_cnt_in   = b_cnt_ff;
      a_idx_in   = a_idx_ff;
      b_idx_in   = b_idx_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (func)
                  FUNC_LOAD_A: begin
                     if (a_full) dropped_in = 1'b1;
                     else        a_cnt_in   = a_cnt_ff + CNT_W'(1);
                  end
                  FUNC_LOAD_B: begin
                     if (b_full) dropped_in = 1'b1;
                     else        b_cnt_in   = b_cnt_ff + CNT_W'(1);
                  end
                  FUNC_MERGE: begin
                     a_idx_in = '0;
                     b_idx_in = '0;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // head terms are being read out of the stores
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (term_last) begin
                  a_cnt_in = '0;
                  b_cnt_in = '0;
                  a_idx_in = '0;
                  b_idx_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  a_idx_in = a_idx_next;
                  b_idx_in = b_idx_next;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register next values
   always_comb begin
      rsp_coef_in  = rsp_coef_ff;
      rsp_power_in = rsp_power_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_coef_in  = term_coef;
         rsp_power_in = pow_out_ext[POW_IO_W-1:0];
         rsp_last_in  = term_last;
         rsp_empty_in = term_empty;
         rsp_ovf_in   = dropped_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         a_idx_ff     <= '0;
         b_idx_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_cnt_ff     <= a_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         a_idx_ff     <= a_idx_in;
         b_idx_ff     <= b_idx_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_coef_ff  <= rsp_coef_in;
      rsp_power_ff <= rsp_power_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_coef  = rsp_coef_ff;
   assign rsp_out_power = rsp_power_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (a_cnt_ff <= MAX_CNT) && (b_cnt_ff <= MAX_CNT))
      else $error("list count beyond capacity");

   dropped_sticky: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |=> dropped_ff)
      else $error("overflow flag cleared without reset");

   last_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && term_last) |=> (a_cnt_ff == '0) && (b_cnt_ff == '0)
         && (state_ff == ST_IDLE))
      else $error("lists not cleared after final result");

   empty_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> rsp_last && (rsp_sum_coef == '0)
         && (rsp_out_power == '0))
      else $error("empty result beat carries term data");

endmodule

[rtl/core/spm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module spm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/spm_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_alu: compare and add unit for the merge
// Picks the higher-power head term, or sums both on equal powers.
// ----------------------------------------------------------------------------
module spm_alu (
   input  logic                            a_live,
   input  logic                            b_live,
   input  spm_pkg::term_type               a_term,
   input  spm_pkg::term_type               b_term,
   output logic signed [spm_pkg::SUM_W-1:0] term_coef,
   output logic [spm_pkg::POWER_WIDTH-1:0] term_power,
   output spm_pkg::sel_type                sel
);
   import spm_pkg::*;

   logic signed [SUM_W-1:0] a_ext;
   logic signed [SUM_W-1:0] b_ext;

   // head selection: larger power first, both on a tie
   always_comb begin
      sel = '0;
      priority if (a_live && b_live) begin
         if (a_term.power > b_term.power) begin
            sel.take_a = 1'b1;
         end else if (a_term.power < b_term.power) begin
            sel.take_b = 1'b1;
         end else begin
            sel.take_a = 1'b1;
            sel.take_b = 1'b1;
         end
      end else if (a_live) begin
         sel.take_a = 1'b1;
      end else if (b_live) begin
         sel.take_b = 1'b1;
      end else begin
         // both lists used up: nothing taken
         sel = '0;
      end
   end

   // shared adder; an untaken side contributes zero
   assign a_ext = sel.take_a ? SUM_W'(a_term.coef) : '0;
   assign b_ext = sel.take_b ? SUM_W'(b_term.coef) : '0;
   assign term_coef = a_ext + b_ext;

   // nothing taken only on an empty merge: power reads zero
   assign term_power = sel.take_a ? a_term.power :
                       (sel.take_b ? b_term.power : '0);

endmodule

[verif/sparse_polynomial_merge_add_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add_tb: self-checking bench for the merge adder
// Loads term lists A and B, requests merges and checks every result beat
// against an in-bench sum predictor. The request side idles and the result
// side stalls at random per phase. One long result hold-off fills the block,
// and the last phase overfills both lists.
// ----------------------------------------------------------------------------
module sparse_polynomial_merge_add_tb;
   import spm_pkg::*;

   // one request beat as queued for the driver
   typedef struct {
      func_type                 func;
      logic signed [COEF_W-1:0] coef;
      logic [POW_IO_W-1:0]      power;
   } request_beat_type;

   // one predicted result beat
   typedef struct {
      logic signed [SUM_W-1:0] sum_coef;
      logic [POW_IO_W-1:0]     power;
      logic                    last;
      logic                    empty_res;
      logic                    overflow;
   } term_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func  = '0;
   logic signed [COEF_W-1:0] req_coef  = '0;
   logic [POW_IO_W-1:0]      req_power = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]  rsp_sum_coef;
   logic [POW_IO_W-1:0]      rsp_out_power;
   logic                     rsp_last;
   logic                     rsp_empty_res;
   logic                     rsp_overflow;

   sparse_polynomial_merge_add u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_coef      (req_coef),
      .req_power     (req_power),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_coef  (rsp_sum_coef),
      .rsp_out_power (rsp_out_power),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and expectation stores
   request_beat_type request_queue [$];
   term_result_type  expected_terms [$];

   // predictor copy of the list state
   logic signed [COEF_W-1:0] a_coef [MAX_TERMS];
   logic [POW_IO_W-1:0]      a_pow  [MAX_TERMS];
   logic signed [COEF_W-1:0] b_coef [MAX_TERMS];
   logic [POW_IO_W-1:0]      b_pow  [MAX_TERMS];
   int a_held = 0;
   int b_held = 0;
   bit dropped_seen = 1'b0;

   // idle control, set by the sequence process; hold_seen and hold_left by the hold-off process
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // bookkeeping
   int  errors       = 0;
   int  beats_queued = 0;
   int  beats_taken  = 0;
   int  work_items   = 0;
   int  merges_seen  = 0;
   int  results_seen = 0;
   int  zero_sums    = 0;
   int  empty_merges = 0;
   bit  beat_taken   = 1'b0;

   // list append with the full-list drop rule
   task automatic append_term(input bit to_b, input logic signed [COEF_W-1:0] coef,
                              input logic [POW_IO_W-1:0] power);
      if (to_b) begin
         if (b_held >= MAX_TERMS) dropped_seen = 1'b1;
         else begin
            b_coef[b_held] = coef;
            b_pow[b_held]  = power;
            b_held++;
         end
      end else begin
         if (a_held >= MAX_TERMS) dropped_seen = 1'b1;
         else begin
            a_coef[a_held] = coef;
            a_pow[a_held]  = power;
            a_held++;
         end
      end
   endtask

   // work out the result beats one accepted request causes
   task automatic predict_request(input logic [FUNC_W-1:0] func,
                                  input logic signed [COEF_W-1:0] coef,
                                  input logic [POW_IO_W-1:0] power);
      term_result_type t;
      int i;
      int j;
      logic signed [SUM_W-1:0] s;
      logic [POW_IO_W-1:0] p;
      case (func)
         FUNC_LOAD_A: append_term(1'b0, coef, power);
         FUNC_LOAD_B: append_term(1'b1, coef, power);
         FUNC_MERGE: begin
            merges_seen++;
            if (a_held == 0 && b_held == 0) begin
               t.sum_coef  = '0;
               t.power     = '0;
               t.last      = 1'b1;
               t.empty_res = 1'b1;
               t.overflow  = dropped_seen;
               expected_terms.push_back(t);
               empty_merges++;
            end else begin
               i = 0;
               j = 0;
               while (i < a_held || j < b_held) begin
                  if (j >= b_held || (i < a_held && a_pow[i] > b_pow[j])) begin
                     s = SUM_W'(a_coef[i]);
                     p = a_pow[i];
                     i++;
                  end else if (i >= a_held || a_pow[i] < b_pow[j]) begin
                     s = SUM_W'(b_coef[j]);
                     p = b_pow[j];
                     j++;
                  end else begin
                     // equal powers: add, keep even a zero sum
                     s = SUM_W'(a_coef[i]);
                     s = s + SUM_W'(b_coef[j]);
                     p = a_pow[i];
                     if (s == 0) zero_sums++;
                     i++;
                     j++;
                  end
                  t.sum_coef  = s;
                  t.power     = p;
                  t.last      = (i >= a_held && j >= b_held);
                  t.empty_res = 1'b0;
                  t.overflow  = dropped_seen;
                  expected_terms.push_back(t);
               end
            end
            a_held = 0;
            b_held = 0;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string what, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // scoreboard: result beats first, then the request beat of this edge
   always @(posedge clock) begin
      term_result_type want;
      beat_taken <= !reset && req_valid && (req_stall === 1'b0);
      if (!reset) begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            results_seen++;
            if (expected_terms.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat, expected none, actual coef %0d power %0d",
                        $time, rsp_sum_coef, rsp_out_power);
            end else begin
               want = expected_terms.pop_front();
               check_field("sum_coef", 64'(want.sum_coef), 64'(rsp_sum_coef));
               check_field("out_power", 64'(want.power), 64'(rsp_out_power));
               check_field("last", 64'(want.last), 64'(rsp_last));
               check_field("empty_res", 64'(want.empty_res), 64'(rsp_empty_res));
               check_field("overflow", 64'(want.overflow), 64'(rsp_overflow));
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            predict_request(req_func, req_coef, req_power);
            beats_taken++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      request_beat_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            r = request_queue.pop_front();
            req_valid <= 1'b1;
            req_func  <= r.func;
            req_coef  <= r.coef;
            req_power <= r.power;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long result hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic queue_request(input func_type func, input logic signed [COEF_W-1:0] coef,
                                input logic [POW_IO_W-1:0] power);
      request_beat_type r;
      r.func  = func;
      r.coef  = coef;
      r.power = power;
      request_queue.push_back(r);
      beats_queued++;
      if (func != FUNC_NONE) work_items++;
   endtask

   function automatic logic signed [COEF_W-1:0] random_coef();
      case ($urandom_range(7))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic int next_power(input int cur);
      int n;
      n = cur - $urandom_range(1, 3);
      return (n < 0) ? 0 : n;
   endfunction

   function automatic int pick_size(input bit allow_big);
      if (allow_big && $urandom_range(7) == 0) return $urandom_range(16, MAX_TERMS);
      return $urandom_range(0, 5);
   endfunction

   // two interleaved lists, descending unless shuffled, with random content, then a merge
   task automatic queue_poly_pair(input bit allow_big);
      int na;
      int nb;
      int ia;
      int ib;
      int cur_a;
      int cur_b;
      bit shuffled;
      na = pick_size(allow_big);
      nb = pick_size(allow_big);
      cur_a = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535);
      // shared start makes equal powers common
      cur_b = $urandom_range(1) ? cur_a : $urandom_range(65535);
      shuffled = ($urandom_range(9) == 0);
      ia = 0;
      ib = 0;
      while (ia < na || ib < nb) begin
         if ($urandom_range(19) == 0) queue_request(FUNC_NONE, $urandom, 16'($urandom));
         if (ib >= nb || (ia < na && $urandom_range(1))) begin
            queue_request(FUNC_LOAD_A, random_coef(),
                          16'(shuffled ? $urandom_range(65535) : cur_a));
            cur_a = next_power(cur_a);
            ia++;
         end else begin
            queue_request(FUNC_LOAD_B, random_coef(),
                          16'(shuffled ? $urandom_range(65535) : cur_b));
            cur_b = next_power(cur_b);
            ib++;
         end
      end
      queue_request(FUNC_MERGE, $urandom, 16'($urandom));
   endtask

   task automatic wait_all_taken();
      while (beats_taken != beats_queued) @(posedge clock);
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      @(posedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // run sequence
   initial begin
      int target;
      int k;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // directed: both lists empty
      queue_request(FUNC_MERGE, '0, '0);
      // extreme coefficients and powers, equal powers on both sides
      queue_request(FUNC_LOAD_A, 32'sh7fff_ffff, 16'hffff);
      queue_request(FUNC_LOAD_A, 32'sh8000_0000, 16'h0000);
      queue_request(FUNC_LOAD_B, 32'sh7fff_ffff, 16'hffff);
      queue_request(FUNC_LOAD_B, 32'sh8000_0000, 16'h0000);
      queue_request(FUNC_MERGE, '0, '0);
      // only A holds terms
      queue_request(FUNC_LOAD_A, 32'sd1, 16'd5);
      queue_request(FUNC_LOAD_A, -32'sd1, 16'd3);
      queue_request(FUNC_MERGE, 32'sh5555_aaaa, 16'ha5a5);
      // only B holds terms
      queue_request(FUNC_LOAD_B, 32'sd7, 16'd100);
      queue_request(FUNC_MERGE, '0, '0);
      // equal powers that cancel to zero
      queue_request(FUNC_LOAD_A, 32'sd5, 16'd10);
      queue_request(FUNC_LOAD_B, -32'sd5, 16'd10);
      queue_request(FUNC_MERGE, '0, '0);
      // ascending order in A, ignored code mixed in
      queue_request(FUNC_LOAD_A, 32'sd1, 16'd2);
      queue_request(FUNC_NONE, 32'sh7fff_ffff, 16'hffff);
      queue_request(FUNC_LOAD_A, 32'sd3, 16'd9);
      queue_request(FUNC_LOAD_B, 32'sd4, 16'd5);
      queue_request(FUNC_MERGE, '0, '0);
      wait_all_taken();

      // no idling, then a long result hold-off while requests keep coming
      target = work_items + 35;
      while (work_items < target) queue_poly_pair(1'b1);
      wait_all_taken();
      @(negedge clock) hold_asks = hold_asks + 1;
      repeat (4) queue_poly_pair(1'b0);
      wait_all_taken();

      set_idling(62, 0);
      target = work_items + 35;
      while (work_items < target) queue_poly_pair(1'b1);
      wait_all_taken();

      set_idling(0, 62);
      target = work_items + 35;
      while (work_items < target) queue_poly_pair(1'b1);
      wait_all_taken();

      set_idling(20, 20);
      target = work_items + 25;
      while (work_items < target) queue_poly_pair(1'b1);
      // overfill A, then B; the overflow flag stays set afterwards
      for (k = 0; k < MAX_TERMS + 2; k++)
         queue_request(FUNC_LOAD_A, random_coef(), 16'(65535 - k));
      for (k = 0; k < 3; k++)
         queue_request(FUNC_LOAD_B, random_coef(), 16'(65535 - 2 * k));
      queue_request(FUNC_MERGE, '0, '0);
      for (k = 0; k < MAX_TERMS + 1; k++)
         queue_request(FUNC_LOAD_B, random_coef(), 16'(MAX_TERMS + 1 - k));
      queue_request(FUNC_MERGE, '0, '0);
      queue_poly_pair(1'b0);
      queue_request(FUNC_MERGE, '0, '0);
      wait_all_taken();

      // drain and let the block settle
      while (expected_terms.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d request beats, %0d merges, %0d result beats",
               beats_taken, merges_seen, results_seen);
      $display("zero-sum terms %0d, empty merges %0d, list overflow %0s",
               zero_sums, empty_merges, dropped_seen ? "reached" : "not reached");
      if (errors == 0 && expected_terms.size() == 0) begin
         $display("sparse_polynomial_merge_add_tb OK");
      end else begin
         $display("sparse_polynomial_merge_add_tb NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("sparse_polynomial_merge_add_tb NOT OK");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/spm_pkg.sv
rtl/core/spm_ram.sv
rtl/core/spm_alu.sv
rtl/core/sparse_polynomial_merge_add.sv
verif/sparse_polynomial_merge_add_tb.sv
